>>> rtl/fgpp_pkg.sv
package fgpp_pkg;

  localparam int SAMPLE_W = 8;
  localparam int REG_W = 13;
  localparam int HALF_W = 12;
  localparam int SUM_W = 40;
  localparam int GPP_W = 25;
  localparam int DIV_W = 27;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int REG_MAX = (1 << REG_W) - 1;
  localparam logic [REG_W-1:0] WIDTH_RST = REG_W'(1920);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(1080);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [HALF_W-1:0] half_w;
    logic [HALF_W-1:0] half_h;
  } job_t;

endpackage

>>> rtl/frame_gradient_per_pixel_top.sv
// Channel   Handshake          Payload
// input     push / full        sample (8 bits, raster order, luma then UV)
// result    empty / pop        gpp_q16 (25 bits), gradient_sum (40 bits)
// config    cfg_we (no wait)   cfg_index, cfg_data (13 bits)
//
// One sample per cycle unless full; line store read at accept, written next cycle.
// One result per frame, after its last sample: the bit-serial divider retires one
// quotient bit per cycle.
// A two-entry frame queue sits between the pixel path and the divider.
// full rises only when the queue has no room for a finished frame.
// Synchronous reset, no clearing pass; a width or height write restarts the frame.
module frame_gradient_per_pixel_top #(
  parameter int MAX_WIDTH = fgpp_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = fgpp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [fgpp_pkg::SAMPLE_W-1:0]  sample,
  output logic                           empty,
  input  logic                           pop,
  output logic [fgpp_pkg::GPP_W-1:0]     gpp_q16,
  output logic [fgpp_pkg::SUM_W-1:0]     gradient_sum,
  input  logic                           cfg_we,
  input  logic [fgpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgpp_pkg::REG_W-1:0]     cfg_data
);
  import fgpp_pkg::*;

  logic job_push;
  job_t job_in;
  job_t job_out;
  logic job_valid;
  logic job_pop;
  logic [Q_CNT_W-1:0] q_count;

  fgpp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_count(q_count),
    .job_push(job_push), .job(job_in)
  );

  fgpp_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr_en(job_push), .wr_data(job_in),
    .rd_en(job_pop), .rd_data(job_out),
    .not_empty(job_valid), .count(q_count)
  );

  fgpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid), .job(job_out), .job_pop(job_pop),
    .pop(pop), .empty(empty),
    .gpp_q16(gpp_q16), .gradient_sum(gradient_sum)
  );

endmodule

>>> rtl/fgpp_front.sv
module fgpp_front #(
  parameter int MAX_WIDTH = fgpp_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [fgpp_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               cfg_we,
  input  logic [fgpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgpp_pkg::REG_W-1:0]         cfg_data,
  input  logic [fgpp_pkg::Q_CNT_W-1:0]       q_count,
  output logic                               job_push,
  output fgpp_pkg::job_t                     job
);
  import fgpp_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PW = (ADDR_W + 1 > REG_W) ? ADDR_W + 1 : REG_W;

  function automatic logic [REG_W-1:0] even_dim(input logic [REG_W-1:0] v, input int cap);
    logic [REG_W-1:0] r;
    r = v;
    if (int'(v) > cap) r = REG_W'(cap);
    r[0] = 1'b0;
    if (r < REG_W'(2)) r = REG_W'(2);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] absdiff(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [SAMPLE_W-1:0] mem [MAX_WIDTH];

  logic [REG_W-1:0] w_eff;
  logic [REG_W-1:0] h_eff;
  logic [ADDR_W-1:0] col;
  logic [REG_W-1:0] row;
  logic chroma;
  logic [SAMPLE_W-1:0] prev;
  logic [SAMPLE_W-1:0] prev2;
  logic [SUM_W-1:0] sum;

  logic s1_valid;
  logic s1_last;
  logic s1_right;
  logic s1_down;
  logic [SAMPLE_W-1:0] s1_cur;
  logic [SAMPLE_W-1:0] s1_left;
  logic [SAMPLE_W-1:0] s1_above;
  logic [ADDR_W-1:0] s1_addr;

  logic accept;
  logic [REG_W-1:0] rows;
  logic [PW-1:0] col_ext;
  logic [PW-1:0] w_ext;
  logic last_col;
  logic last_row;
  logic right_en;
  logic down_en;
  logic [SAMPLE_W:0] add;
  logic [SUM_W-1:0] sum_next;

  assign full = ({1'b0, q_count} + (Q_CNT_W+1)'(s1_valid && s1_last))
                >= (Q_CNT_W+1)'(Q_DEPTH);
  assign accept = push && !full;

  always_comb begin
    rows = chroma ? {1'b0, h_eff[REG_W-1:1]} : h_eff;
    col_ext = PW'(col);
    w_ext = PW'(w_eff);
    last_col = col_ext == w_ext - PW'(1);
    last_row = row == rows - REG_W'(1);
    if (chroma) begin
      right_en = !last_row && col_ext >= PW'(2);
      down_en = row != '0 && (col_ext + PW'(2) < w_ext);
    end else begin
      right_en = !last_row && col_ext != '0;
      down_en = row != '0 && !last_col;
    end
  end

  always_comb begin
    add = (s1_right ? {1'b0, absdiff(s1_left, s1_cur)} : '0)
        + (s1_down ? {1'b0, absdiff(s1_above, s1_cur)} : '0);
    sum_next = sum + SUM_W'(add);
  end

  assign job_push = s1_valid && s1_last;
  assign job.sum = sum_next;
  assign job.half_w = w_eff[REG_W-1:1];
  assign job.half_h = h_eff[REG_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WIDTH_RST;
      h_eff <= HEIGHT_RST;
      col <= '0;
      row <= '0;
      chroma <= 1'b0;
      prev <= '0;
      prev2 <= '0;
      sum <= '0;
      s1_valid <= 1'b0;
      s1_last <= 1'b0;
      s1_right <= 1'b0;
      s1_down <= 1'b0;
    end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
      if (cfg_index == REG_FRAME_WIDTH) w_eff <= even_dim(cfg_data, MAX_WIDTH);
      else h_eff <= even_dim(cfg_data, REG_MAX);
      col <= '0;
      row <= '0;
      chroma <= 1'b0;
      prev <= '0;
      prev2 <= '0;
      sum <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_last <= last_col && last_row && chroma;
        s1_right <= right_en;
        s1_down <= down_en;
        if (last_col && last_row && chroma) begin
          prev <= '0;
          prev2 <= '0;
        end else begin
          prev <= sample;
          prev2 <= prev;
        end
        if (last_col) begin
          col <= '0;
          if (last_row) begin
            row <= '0;
            chroma <= !chroma;
          end else begin
            row <= row + REG_W'(1);
          end
        end else begin
          col <= col + ADDR_W'(1);
        end
      end
      if (s1_valid) sum <= s1_last ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur <= sample;
      s1_left <= chroma ? prev2 : prev;
      s1_addr <= col;
      s1_above <= mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) mem[s1_addr] <= s1_cur;
  end

endmodule

>>> rtl/fgpp_fifo.sv
module fgpp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  fgpp_pkg::job_t               wr_data,
  input  logic                         rd_en,
  output fgpp_pkg::job_t               rd_data,
  output logic                         not_empty,
  output logic [fgpp_pkg::Q_CNT_W-1:0] count
);
  import fgpp_pkg::*;

  job_t store [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;

  assign not_empty = count != '0;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + Q_AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + Q_AW'(1);
      count <= count + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= wr_data;
  end

endmodule

>>> rtl/fgpp_back.sv
module fgpp_back #(
  parameter int FRAC_BITS = fgpp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  fgpp_pkg::job_t                 job,
  output logic                           job_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [fgpp_pkg::GPP_W-1:0]     gpp_q16,
  output logic [fgpp_pkg::SUM_W-1:0]     gradient_sum
);
  import fgpp_pkg::*;

  localparam int NQ_W = SUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NQ_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;
  logic [SUM_W-1:0] sum_hold;
  logic [HALF_W-1:0] half_w;
  logic [HALF_W-1:0] half_h;
  logic [2*HALF_W-1:0] prod;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] rem;
  logic [NQ_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic out_valid;

  logic [DIV_W:0] trial;
  logic ge;
  logic out_load;

  assign job_pop = state == ST_IDLE && job_valid;
  assign empty = !out_valid;
  assign out_load = state == ST_DONE && (!out_valid || pop);

  always_comb begin
    trial = {rem, quo[NQ_W-1]};
    ge = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (job_valid) state <= ST_MUL;
        ST_MUL: state <= ST_SCALE;
        ST_SCALE: begin
          cnt <= CNT_W'(NQ_W);
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) state <= ST_DONE;
        end
        ST_DONE: if (out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sum_hold <= job.sum;
        half_w <= job.half_w;
        half_h <= job.half_h;
      end
      ST_MUL: begin
        prod <= (2*HALF_W)'(half_w) * (2*HALF_W)'(half_h);
        quo <= {sum_hold, {FRAC_BITS{1'b0}}};
        rem <= '0;
      end
      ST_SCALE: divisor <= DIV_W'({prod, 2'b00}) + DIV_W'({prod, 1'b0});
      ST_DIV: begin
        rem <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
        quo <= {quo[NQ_W-2:0], ge};
      end
      default: ;
    endcase
    if (out_load) begin
      gradient_sum <= sum_hold;
      gpp_q16 <= (quo[NQ_W-1:GPP_W] != '0) ? {GPP_W{1'b1}} : quo[GPP_W-1:0];
    end
  end

endmodule

>>> rtl/fgpp_checker.sv
module fgpp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [fgpp_pkg::GPP_W-1:0]    gpp_q16,
  input logic [fgpp_pkg::SUM_W-1:0]    gradient_sum
);
  import fgpp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(gpp_q16) && $stable(gradient_sum))
    else $error("waiting result changed or vanished");

  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    !empty && gradient_sum == '0 |-> gpp_q16 == '0)
    else $error("nonzero gradient for zero sum");

endmodule

bind frame_gradient_per_pixel_top fgpp_checker u_chk (.*);

>>> verif/gradient_checker.sv
`timescale 1ns / 100ps
module gradient_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic [fgpp_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [fgpp_pkg::GPP_W-1:0]     gpp_q16,
  input  logic [fgpp_pkg::SUM_W-1:0]     gradient_sum,
  input  logic                           cfg_we,
  input  logic [fgpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgpp_pkg::REG_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             pending_frames
);
  import fgpp_pkg::*;

  typedef struct packed {
    logic [GPP_W-1:0] gpp;
    logic [SUM_W-1:0] sum;
  } frame_result_t;

  localparam longint unsigned GPP_SAT = (64'd1 << GPP_W) - 1;

  logic [REG_W-1:0]    width_reg = WIDTH_RST;
  logic [REG_W-1:0]    height_reg = HEIGHT_RST;
  logic [SAMPLE_W-1:0] row_above [MAX_WIDTH_DEF];
  logic [SAMPLE_W-1:0] last_px = '0;
  logic [SAMPLE_W-1:0] last2_px = '0;
  int unsigned         row_pos = 0;
  int unsigned         col_pos = 0;
  bit                  chroma_plane = 1'b0;
  logic [SUM_W-1:0]    grad_acc = '0;
  frame_result_t       expected_frames[$];
  int                  err_count = 0;

  function automatic int unsigned snap_dim(input int unsigned v, input int unsigned cap);
    int unsigned d;
    d = (v > cap) ? cap : v;
    d = d & ~32'd1;
    return (d < 2) ? 2 : d;
  endfunction

  function automatic int unsigned abs_diff(input logic [SAMPLE_W-1:0] a,
                                           input logic [SAMPLE_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic restart_frame();
    last_px = '0;
    last2_px = '0;
    row_pos = 0;
    col_pos = 0;
    chroma_plane = 1'b0;
    grad_acc = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data;
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data;
        restart_frame();
      end
      default: ;
    endcase
  endtask

  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] cur);
    int unsigned     w, h, rows, c, r, add;
    longint unsigned divisor, quot;
    w = snap_dim(width_reg, MAX_WIDTH_DEF);
    h = snap_dim(height_reg, REG_MAX);
    rows = chroma_plane ? h / 2 : h;
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = row_pos;
    add = 0;
    if (!chroma_plane) begin
      if (r + 1 < rows && c >= 1) add += abs_diff(last_px, cur);
      if (r >= 1 && c + 2 <= w) add += abs_diff(row_above[c], cur);
    end else begin
      if (r + 1 < rows && c >= 2) add += abs_diff(last2_px, cur);
      if (r >= 1 && c + 3 <= w) add += abs_diff(row_above[c], cur);
    end
    grad_acc = grad_acc + SUM_W'(add);
    row_above[c] = cur;
    last2_px = last_px;
    last_px = cur;

    c++;
    if (c < w) begin
      col_pos = c;
    end else begin
      col_pos = 0;
      r++;
      if (r < rows) begin
        row_pos = r;
      end else begin
        row_pos = 0;
        if (!chroma_plane) begin
          chroma_plane = 1'b1;
        end else begin
          divisor = 64'd6 * (w / 2) * (h / 2);
          quot = (64'(grad_acc) << FRAC_BITS_DEF) / divisor;
          if (quot > GPP_SAT) quot = GPP_SAT;
          expected_frames.push_back('{gpp: GPP_W'(quot), sum: grad_acc});
          restart_frame();
        end
      end
    end
  endtask

  task automatic check_result();
    frame_result_t exp_r;
    if (expected_frames.size() == 0) begin
      err_count++;
      $display("%0t: unexpected transaction, expected none, actual gpp_q16 %0d gradient_sum %0d",
               $time, gpp_q16, gradient_sum);
    end else begin
      exp_r = expected_frames.pop_front();
      if (gpp_q16 !== exp_r.gpp) begin
        err_count++;
        $display("%0t: gpp_q16 mismatch, expected %0d, actual %0d", $time, exp_r.gpp, gpp_q16);
      end
      if (gradient_sum !== exp_r.sum) begin
        err_count++;
        $display("%0t: gradient_sum mismatch, expected %0d, actual %0d",
                 $time, exp_r.sum, gradient_sum);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      restart_frame();
      expected_frames.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_data);
      if (push && !full) accumulate_sample(sample);
      if (pop && !empty) check_result();
    end
    mismatches <= err_count;
    pending_frames <= expected_frames.size();
  end

endmodule

>>> verif/tb_frame_gradient_per_pixel_top.sv
`timescale 1ns / 100ps
module tb_frame_gradient_per_pixel_top;
  import fgpp_pkg::*;

  localparam int DRAIN_CYCLES = 5 + SUM_W + FRAC_BITS_DEF + 20;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int unsigned ITEM_TARGET = 1700;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_SMOOTH, PIX_FLAT, PIX_CHECKER} pix_pattern_t;
  typedef enum {POP_EAGER, POP_COIN, POP_SLOW} pop_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [GPP_W-1:0]     gpp_q16;
  logic [SUM_W-1:0]     gradient_sum;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  int          mismatches;
  int          pending_frames;
  int          cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned pop_hold = 0;
  pop_style_t  pop_style = POP_EAGER;
  int unsigned w_reg = WIDTH_RST;
  int unsigned h_reg = HEIGHT_RST;

  always #5 clk = ~clk;

  frame_gradient_per_pixel_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .empty       (empty),
    .pop         (pop),
    .gpp_q16     (gpp_q16),
    .gradient_sum(gradient_sum),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  gradient_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample        (sample),
    .empty         (empty),
    .pop           (pop),
    .gpp_q16       (gpp_q16),
    .gradient_sum  (gradient_sum),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_frames(pending_frames)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: the stall style for pop changes at random
  always @(negedge clk) begin
    if (pop_hold == 0) begin
      pop_style <= pop_style_t'($urandom_range(0, 2));
      pop_hold <= $urandom_range(20, 120);
    end else begin
      pop_hold <= pop_hold - 1;
    end
    case (pop_style)
      POP_EAGER: pop <= 1'b1;
      POP_COIN:  pop <= 1'($urandom_range(0, 1));
      default:   pop <= (cycle_count % 13 == 0);
    endcase
  end

  function automatic int unsigned snap_dim(input int unsigned v, input int unsigned cap);
    int unsigned d;
    d = (v > cap) ? cap : v;
    d = d & ~32'd1;
    return (d < 2) ? 2 : d;
  endfunction

  function automatic int unsigned frame_len(input int unsigned wr, input int unsigned hr);
    int unsigned w, h;
    w = snap_dim(wr, MAX_WIDTH_DEF);
    h = snap_dim(hr, REG_MAX);
    return w * h + w * (h / 2);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push = 1'b1;
    sample = v;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_pixels(input int unsigned n, input pix_pattern_t pattern,
                             input int unsigned w);
    logic [SAMPLE_W-1:0] v, base;
    int                  step;
    base = $urandom_range(0, 255);
    v = base;
    for (int unsigned i = 0; i < n; i++) begin
      case (pattern)
        PIX_RANDOM:  v = $urandom_range(0, 255);
        PIX_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_SMOOTH: begin
          step = int'(v) + int'($urandom_range(0, 8)) - 4;
          v = (step < 0) ? 8'h00 : (step > 255) ? 8'hFF : SAMPLE_W'(step);
        end
        PIX_FLAT:    v = base;
        default:     v = (((i % w) + (i / w)) & 1) ? 8'hFF : 8'h00;
      endcase
      send_sample(v);
    end
  endtask

  task automatic send_frame(input pix_pattern_t pattern);
    send_pixels(frame_len(w_reg, h_reg), pattern, snap_dim(w_reg, MAX_WIDTH_DEF));
  endtask

  // wait for every outstanding transaction and for the divider to go quiet
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    burst_left = 0;
    while (pending_frames != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = REG_W'(data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    w_reg = w;
    h_reg = h;
  endtask

  initial begin
    int unsigned w, h, len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // frame at reset size, cut short; the register write restarts it
    send_pixels(3, PIX_RANDOM, WIDTH_RST);
    set_frame_size(4, 4);
    send_frame(PIX_CHECKER);

    // tiny size rounds up to 2x2; a write to the spare index leaves the frame alone
    set_frame_size(0, 1);
    send_pixels(3, PIX_EXTREME, 2);
    settle();
    write_reg(REG_SPARE, REG_MAX);
    send_pixels(3, PIX_EXTREME, 2);

    while (items_sent < ITEM_TARGET) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
      set_frame_size(w, h);
      len = frame_len(w, h);
      repeat ($urandom_range(1, 3)) begin
        if (items_sent >= ITEM_TARGET) break;
        if ($urandom_range(0, 7) == 0) begin
          send_pixels($urandom_range(1, len - 1), pix_pattern_t'($urandom_range(0, 4)),
                      snap_dim(w, MAX_WIDTH_DEF));
          break;
        end
        send_frame(pix_pattern_t'($urandom_range(0, 4)));
      end
    end

    settle();
    if (mismatches == 0 && pending_frames == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fgpp_pkg.sv
rtl/fgpp_front.sv
rtl/fgpp_fifo.sv
rtl/fgpp_back.sv
rtl/frame_gradient_per_pixel_top.sv
rtl/fgpp_checker.sv
verif/gradient_checker.sv
verif/tb_frame_gradient_per_pixel_top.sv
